>>> rtl/class_argmax_palette_mapper_defines.svh
// assertion macros shared by the class argmax palette mapper rtl
// expects signals clk and rst in the scope where a macro is used
`ifndef CLASS_ARGMAX_PALETTE_MAPPER_DEFINES_SVH
`define CLASS_ARGMAX_PALETTE_MAPPER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CAM_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CAM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/cam_pkg.sv
// shared types, constants and the voc palette table for the argmax mapper
// no dependencies
package cam_pkg;

  localparam int SCORE_W          = 32;
  localparam int CLASS_W          = 5;
  localparam int COLOUR_W         = 8;
  localparam int PALETTE_SIZE     = 21;
  localparam int MAX_CHANNELS_DEF = 32;

  // packed as red, green, blue
  localparam logic [3*COLOUR_W-1:0] PALETTE [PALETTE_SIZE] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000, 24'h000080,
    24'h800080, 24'h008080, 24'h808080, 24'h400000, 24'hC00000,
    24'h408000, 24'hC08000, 24'h400080, 24'hC00080, 24'h408080,
    24'hC08080, 24'h004000, 24'h804000, 24'h00C000, 24'h80C000,
    24'h004080
  };

  // end-of-pixel summary handed from the argmax unit to the output stage
  typedef struct packed {
    logic               done;
    logic [CLASS_W-1:0] class_index;
    logic               miss;
    logic               overflow;
  } pixel_t;

  // maps a float bit pattern onto an unsigned key that orders like the value
  function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] bits);
    logic [SCORE_W-1:0] b;
    b = (bits[SCORE_W-2:0] == '0) ? '0 : bits;
    if (b[SCORE_W-1]) begin
      return ~b;
    end
    return {1'b1, b[SCORE_W-2:0]};
  endfunction

  function automatic logic [3*COLOUR_W-1:0] palette_rgb(input logic [CLASS_W-1:0] idx);
    if (idx < CLASS_W'(PALETTE_SIZE)) begin
      return PALETTE[idx];
    end
    return '0;
  endfunction

endpackage

>>> rtl/cam_argmax.sv
// running maximum over the class scores of one pixel
// depends on cam_pkg
module cam_argmax import cam_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [SCORE_W-1:0] score,
  input  logic               last_channel,
  output pixel_t             pixel
);

  localparam int POS_W = $clog2(MAX_CHANNELS + 1);
  localparam int CLS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EXT_W = (CLS_W > CLASS_W) ? CLS_W : CLASS_W;
  localparam int MAX_INDEX = (1 << CLASS_W) - 1;

  logic [SCORE_W-1:0] best_key, best_key_next;
  logic [CLS_W-1:0]   best_class, best_class_next;
  logic [POS_W-1:0]   channel_position;
  logic               overflow_seen, overflow_next;

  logic [SCORE_W-1:0] key;
  logic               take, better;
  logic [EXT_W-1:0]   idx_ext;

  always_comb begin
    key  = order_key(score);
    take = channel_position < POS_W'(MAX_CHANNELS);
    // first score of a pixel wins outright, later ones only when strictly larger
    better = (channel_position == '0) || (key > best_key);
    best_key_next   = best_key;
    best_class_next = best_class;
    if (take && better) begin
      best_key_next   = key;
      best_class_next = channel_position[CLS_W-1:0];
    end
    overflow_next = overflow_seen | ~take;

    idx_ext = EXT_W'(best_class_next);
    pixel.done        = step & last_channel;
    pixel.class_index = (idx_ext > EXT_W'(MAX_INDEX)) ? '1 : idx_ext[CLASS_W-1:0];
    pixel.miss        = idx_ext >= EXT_W'(PALETTE_SIZE);
    pixel.overflow    = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_key         <= '0;
      best_class       <= '0;
      channel_position <= '0;
      overflow_seen    <= 1'b0;
    end else if (step) begin
      if (last_channel) begin
        best_key         <= '0;
        best_class       <= '0;
        channel_position <= '0;
        overflow_seen    <= 1'b0;
      end else begin
        best_key      <= best_key_next;
        best_class    <= best_class_next;
        overflow_seen <= overflow_next;
        if (take) begin
          channel_position <= channel_position + POS_W'(1);
        end
      end
    end
  end

endmodule

>>> rtl/class_argmax_palette_mapper.sv
// Class argmax with PASCAL VOC colouring. One float32 class score is taken per
// beat, every cycle while the result register is free; a pixel's result
// appears in the cycle after the beat flagged last_channel is taken. The single 32-bit
// key compare feeding the palette lookup sets the one-cycle-per-score rate.
// Ties keep the lower channel, -0 equals +0, classes of 21 and above come out
// black with palette_miss, and scores past MAX_CHANNELS are dropped with
// channel_overflow reported at the end of the pixel.
// depends on cam_pkg, cam_argmax and class_argmax_palette_mapper_defines.svh
`include "class_argmax_palette_mapper_defines.svh"

module class_argmax_palette_mapper import cam_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SCORE_W-1:0]  score,
  input  logic                last_channel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CLASS_W-1:0]  class_index,
  output logic [COLOUR_W-1:0] red,
  output logic [COLOUR_W-1:0] green,
  output logic [COLOUR_W-1:0] blue,
  output logic                palette_miss,
  output logic                channel_overflow
);

  logic                  accept;
  pixel_t                pixel;
  logic [3*COLOUR_W-1:0] rgb;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  cam_argmax #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_argmax (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .score        (score),
    .last_channel (last_channel),
    .pixel        (pixel)
  );

  assign rgb = pixel.miss ? '0 : palette_rgb(pixel.class_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pixel.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded only when the register is free
  always_ff @(posedge clk) begin
    if (pixel.done) begin
      class_index      <= pixel.class_index;
      red              <= rgb[3*COLOUR_W-1:2*COLOUR_W];
      green            <= rgb[2*COLOUR_W-1:COLOUR_W];
      blue             <= rgb[COLOUR_W-1:0];
      palette_miss     <= pixel.miss;
      channel_overflow <= pixel.overflow;
    end
  end

  `CAM_ASSERT_NEXT(a_last_gives_result, accept && last_channel, out_valid,
    "last beat of a pixel did not raise a result")
  `CAM_ASSERT_NEXT(a_taken_result_clears,
    out_valid && !out_stall && !(accept && last_channel), !out_valid,
    "delivered result was repeated")
  `CAM_ASSERT_IMPLY(a_miss_is_black, out_valid && palette_miss,
    red == '0 && green == '0 && blue == '0, "palette miss with a non-black colour")
  `CAM_ASSERT_IMPLY(a_hit_in_range, out_valid && !palette_miss,
    class_index < CLASS_W'(PALETTE_SIZE), "palette hit for an index past the table")

endmodule

>>> dv/class_argmax_palette_mapper_tb.sv
// testbench for class_argmax_palette_mapper: scores stream in per pixel, results checked beat by beat
// depends on cam_pkg and the rtl top; predicts argmax, voc colour and overflow on its own
module class_argmax_palette_mapper_tb;
  import cam_pkg::*;

  localparam int MAX_CH      = MAX_CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
  } score_beat_t;

  typedef struct packed {
    logic [CLASS_W-1:0]  class_index;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                miss;
    logic                overflow;
  } pixel_colour_t;

  typedef enum int {FILL_ANY, FILL_POOL, FILL_RAMP, FILL_NAN, FILL_LOGIT} fill_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [SCORE_W-1:0]  score        = '0;
  logic                last_channel = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [CLASS_W-1:0]  class_index;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic                palette_miss;
  logic                channel_overflow;

  score_beat_t   score_feed[$];
  pixel_colour_t pixel_expect[$];

  // running argmax of the pixel in progress
  logic [SCORE_W-1:0] top_bits   = '0;
  int unsigned        top_class  = 0;
  int unsigned        seen_count = 0;
  logic               extra_seen = 1'b0;

  int          err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_in    = 0;
  int unsigned beats_out   = 0;
  int          in_gap      = 0;
  int          stall_left  = 0;

  class_argmax_palette_mapper #(
    .MAX_CHANNELS(MAX_CH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .score(score),
    .last_channel(last_channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .class_index(class_index),
    .red(red),
    .green(green),
    .blue(blue),
    .palette_miss(palette_miss),
    .channel_overflow(channel_overflow)
  );

  always #10 clk = ~clk;

  // unsigned rank that orders like the float value, both zeros equal
  function automatic logic [SCORE_W-1:0] score_rank(input logic [SCORE_W-1:0] f);
    if (f[SCORE_W-2:0] == '0) begin
      return {1'b1, {(SCORE_W-1){1'b0}}};
    end
    if (f[SCORE_W-1]) begin
      return ~f;
    end
    return {1'b1, f[SCORE_W-2:0]};
  endfunction

  // every third phase runs without gaps
  function automatic int pick_gap(input int unsigned phase);
    int r;
    r = $urandom_range(0, 99);
    if (phase % 3 == 0) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  task automatic add_beat(input logic [SCORE_W-1:0] s, input logic last);
    score_beat_t b;
    b.score = s;
    b.last  = last;
    score_feed.push_back(b);
  endtask

  task automatic add_pixel(input int n, input fill_t mode);
    logic [SCORE_W-1:0] base;
    logic [SCORE_W-1:0] step;
    logic [SCORE_W-1:0] v;
    base = 32'h3C00_0000 + $urandom_range(0, 1 << 20);
    step = $urandom_range(1, 1000);
    for (int i = 0; i < n; i++) begin
      case (mode)
        FILL_POOL: begin
          // few distinct values so ties and signed zeros come up often
          case ($urandom_range(0, 7))
            0: v = 32'h0000_0000;
            1: v = 32'h8000_0000;
            2: v = 32'h3F80_0000;
            3: v = 32'hBF80_0000;
            4: v = 32'h7F80_0000;
            5: v = 32'hFF80_0000;
            6: v = 32'h4000_0000;
            default: v = 32'hC000_0000;
          endcase
        end
        FILL_RAMP: v = base + step * i;
        FILL_NAN: begin
          if ($urandom_range(0, 3) == 0) begin
            v = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, (1 << 23) - 1))};
          end else begin
            v = {1'($urandom_range(0, 1)), 8'($urandom_range(118, 134)), 23'($urandom)};
          end
        end
        FILL_LOGIT: v = {1'($urandom_range(0, 1)), 8'($urandom_range(118, 134)), 23'($urandom)};
        default: v = $urandom;
      endcase
      add_beat(v, i == n - 1);
    end
  endtask

  task automatic absorb_score(input logic [SCORE_W-1:0] s, input logic last);
    logic [SCORE_W-1:0] v;
    pixel_colour_t      want;
    logic [CLASS_W-1:0] c;
    v = (s[SCORE_W-2:0] == '0) ? '0 : s;
    if (seen_count < MAX_CH) begin
      if (seen_count == 0 || score_rank(v) > score_rank(top_bits)) begin
        top_bits  = v;
        top_class = seen_count;
      end
      seen_count++;
    end else begin
      extra_seen = 1'b1;
    end
    if (last) begin
      c                = (top_class > 31) ? 5'd31 : 5'(top_class);
      want.class_index = c;
      want.miss        = (top_class >= PALETTE_SIZE);
      want.overflow    = extra_seen;
      if (want.miss) begin
        want.red   = '0;
        want.green = '0;
        want.blue  = '0;
      end else begin
        // voc colours interleave the class bits into the top bits of r, g, b
        want.red   = {c[0], c[3], 6'b0};
        want.green = {c[1], c[4], 6'b0};
        want.blue  = {c[2], 7'b0};
      end
      pixel_expect.push_back(want);
      top_bits   = '0;
      top_class  = 0;
      seen_count = 0;
      extra_seen = 1'b0;
    end
  endtask

  // driver: a beat leaves the queue once the previous one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        absorb_score(score, last_channel);
        beats_in <= beats_in + 1;
      end
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (score_feed.size() != 0) begin
        in_valid     <= 1'b1;
        score        <= score_feed[0].score;
        last_channel <= score_feed[0].last;
        void'(score_feed.pop_front());
        in_gap       <= pick_gap(beats_in / 64);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each taken result beat and drives the stall
  always @(posedge clk) begin : result_side
    pixel_colour_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (pixel_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected result class %0d", class_index));
        end else begin
          want = pixel_expect.pop_front();
          if (class_index !== want.class_index || red !== want.red ||
              green !== want.green || blue !== want.blue ||
              palette_miss !== want.miss || channel_overflow !== want.overflow) begin
            flag_mismatch($sformatf(
              "got class %0d rgb %h%h%h miss %b ovf %b, want class %0d rgb %h%h%h miss %b ovf %b",
              class_index, red, green, blue, palette_miss, channel_overflow,
              want.class_index, want.red, want.green, want.blue, want.miss, want.overflow));
          end
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if ((out_valid && !out_stall) || $urandom_range(0, 7) == 0) begin
          stall_left <= pick_gap(beats_out / 8);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("class_argmax_palette_mapper_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    int          n;
    int          r;
    // single score, zero
    add_beat(32'h0000_0000, 1'b1);
    // negative zero ties positive zero, lower index keeps it
    add_beat(32'h8000_0000, 1'b0);
    add_beat(32'h0000_0000, 1'b1);
    // negative zero beats the smallest negative
    add_beat(32'h8000_0001, 1'b0);
    add_beat(32'h8000_0000, 1'b1);
    // extremes: largest negative, minus and plus infinity, largest finite
    add_beat(32'hFF7F_FFFF, 1'b0);
    add_beat(32'hFF80_0000, 1'b0);
    add_beat(32'h7F80_0000, 1'b0);
    add_beat(32'h7F7F_FFFF, 1'b1);
    // equal scores then a smaller one
    add_beat(32'h3F80_0000, 1'b0);
    add_beat(32'h3F80_0000, 1'b0);
    add_beat(32'hBF80_0000, 1'b1);
    // positive nan patterns rank past plus infinity, negative ones below minus infinity
    add_beat(32'hFFFF_FFFF, 1'b0);
    add_beat(32'h7FC0_0000, 1'b1);
    add_beat(32'h0000_0001, 1'b0);
    add_beat(32'h7FFF_FFFF, 1'b1);

    // rising pixels: first class past the palette, full width, and overflow
    add_pixel(22, FILL_RAMP);
    add_pixel(MAX_CH, FILL_RAMP);
    add_pixel(MAX_CH + 4, FILL_RAMP);
    while (score_feed.size() < 740) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(1, 6);
      end else if (r < 80) begin
        n = $urandom_range(7, 20);
      end else if (r < 92) begin
        n = $urandom_range(21, MAX_CH);
      end else begin
        n = $urandom_range(MAX_CH + 1, MAX_CH + 8);
      end
      add_pixel(n, fill_t'($urandom_range(0, 4)));
    end
    total = score_feed.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (beats_in < total) @(posedge clk);
    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pixel_expect.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pixel_expect.size()));
    end
    if (err_count == 0) begin
      $display("class_argmax_palette_mapper_tb OK");
    end else begin
      $display("class_argmax_palette_mapper_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> class_argmax_palette_mapper.f
+incdir+rtl
rtl/cam_pkg.sv
rtl/cam_argmax.sv
rtl/class_argmax_palette_mapper.sv
dv/class_argmax_palette_mapper_tb.sv
